// File: src/pfa_pkg.sv
`default_nettype none

package pfa_pkg;

   // table and address geometry
   localparam int MAX_BLOCKS  = 64;
   localparam int ADDR_BITS   = 20;
   localparam int ADDR_W      = ADDR_BITS;
   localparam int SIZE_W      = ADDR_BITS + 1;
   localparam int IDX_W       = $clog2(MAX_BLOCKS);
   localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
   localparam int PART_W      = 7;
   localparam int FIT_W       = 2;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int ENTRY_W     = ADDR_W + SIZE_W + 2;
   localparam int REQ_TDATA_W = ((SIZE_W + ADDR_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((ADDR_W + STATUS_W + 7) / 8) * 8;
   localparam int DCNT_W      = $clog2(SIZE_W + 1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_REBUILD = 2'd2
   } func_type;

   typedef enum logic [FIT_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_NEXT  = 2'd1,
      FIT_BEST  = 2'd2,
      FIT_WORST = 2'd3
   } fit_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_BADADDR = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIT_MODE   = 2'd0,
      CSR_POOL_BYTES = 2'd1,
      CSR_PART_COUNT = 2'd2
   } csr_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_SCAN_RD,
      CMD_SCAN_EV,
      CMD_NOFIT,
      CMD_FULL,
      CMD_NOADDR,
      CMD_EXACT,
      CMD_UP_START,
      CMD_MV_RD,
      CMD_MV_WR,
      CMD_SPLIT_HI,
      CMD_SPLIT_LO,
      CMD_RD_R,
      CMD_R_EV,
      CMD_PLAN,
      CMD_RB_START,
      CMD_DIV_STEP,
      CMD_RB_WRITE,
      CMD_PUBLISH
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic              used;
      logic              joinable;
   } entry_type;

   typedef struct packed {
      cmd_type cmd;
      logic    take_req;
   } dp_ctl_type;

   typedef struct packed {
      logic              req_valid;
      logic [FUNC_W-1:0] func;
      logic              req_zero;
      logic              out_free;
      logic              ev_stop;
      logic              scan_last;
      logic              pick_valid;
      logic              pick_exact;
      logic              table_full;
      logic              found;
      logic              r_valid;
      logic              mv_done;
      logic              div_done;
      logic              rb_last;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: src/pfa_ram.sv
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/pfa_datapath.sv
`default_nettype none

module pfa_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pfa_pkg::FUNC_W-1:0]       req_tuser,
   input  logic [pfa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pfa_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfa_pkg::SIZE_W-1:0]       csr_wdata,
   input  pfa_pkg::dp_ctl_type              ctl,
   output pfa_pkg::dp_stat_type             stat
);

   localparam int ADDR_W = pfa_pkg::ADDR_W;
   localparam int SIZE_W = pfa_pkg::SIZE_W;
   localparam int IDX_W  = pfa_pkg::IDX_W;
   localparam int CNT_W  = pfa_pkg::CNT_W;
   localparam int PART_W = pfa_pkg::PART_W;
   localparam int DCNT_W = pfa_pkg::DCNT_W;
   localparam int FIT_W  = pfa_pkg::FIT_W;
   localparam int FUNC_W = pfa_pkg::FUNC_W;
   localparam int RSP_W  = pfa_pkg::RSP_TDATA_W;
   localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(pfa_pkg::MAX_BLOCKS);
   localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_W;

   // configuration
   logic [FIT_W-1:0]  fit_mode_ff, fit_mode_in;
   logic [SIZE_W-1:0] pool_ff, pool_in;
   logic [PART_W-1:0] part_cfg_ff, part_cfg_in;
   // table bookkeeping
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  cursor_ff, cursor_in;
   // command
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [SIZE_W-1:0] req_ff, req_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   // scan
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  scan_rem_ff, scan_rem_in;
   logic              pick_valid_ff, pick_valid_in;
   logic [IDX_W-1:0]  pick_idx_ff, pick_idx_in;
   pfa_pkg::entry_type pick_ent_ff, pick_ent_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  fi_ff, fi_in;
   pfa_pkg::entry_type e_ent_ff, e_ent_in, l_ent_ff, l_ent_in, r_ent_ff, r_ent_in;
   logic              r_have_ff, r_have_in;
   // entry mover
   logic [CNT_W-1:0]  dst_ff, dst_in, lim_ff, lim_in;
   logic [1:0]        mv_d_ff, mv_d_in;
   // divider and rebuild
   logic [SIZE_W-1:0] quo_ff, quo_in, acc_ff, acc_in;
   logic [CNT_W-1:0]  rem_ff, rem_in, parts_ff, parts_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;
   // result
   pfa_pkg::status_type res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_grant_ff, res_grant_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   // RAM port
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   pfa_pkg::entry_type wr_ent, rd_ent;
   logic [pfa_pkg::ENTRY_W-1:0] rd_raw;

   // scan evaluation
   logic fits, exact, bigger, better, match, first_like, ev_stop;
   logic [IDX_W-1:0] scan_next;
   // merge plan
   logic               r_ok, pstart, take_left;
   logic [IDX_W-1:0]   p_w;
   logic [1:0]         p_d;
   logic [CNT_W-1:0]   p_r0;
   pfa_pkg::entry_type p_ent;
   // divider step
   logic [CNT_W:0]     div_tr;
   logic               div_ge;
   logic [CNT_W-1:0]   parts_c;
   logic [CNT_W-1:0]   mv_src;

   pfa_ram #(
      .WIDTH (pfa_pkg::ENTRY_W),
      .DEPTH (pfa_pkg::MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_ent = pfa_pkg::entry_type'(rd_raw);

   // candidate tests on the entry just read
   assign fits       = !rd_ent.used && (rd_ent.size >= req_ff);
   assign exact      = !rd_ent.used && (rd_ent.size == req_ff);
   assign bigger     = !rd_ent.used && (rd_ent.size > req_ff);
   assign better     = !pick_valid_ff ||
                       ((fit_mode_ff == pfa_pkg::FIT_BEST) ? (rd_ent.size < pick_ent_ff.size)
                                                           : (rd_ent.size > pick_ent_ff.size));
   assign match      = rd_ent.used && (rd_ent.start == addr_ff);
   assign first_like = (fit_mode_ff == pfa_pkg::FIT_FIRST) || (fit_mode_ff == pfa_pkg::FIT_NEXT);
   assign ev_stop    = (func_ff == pfa_pkg::FUNC_ALLOC) ? (first_like ? fits : exact) : match;
   assign scan_next  = (CNT_W'(scan_idx_ff) + CNT_W'(1) == count_ff) ? '0
                                                                      : scan_idx_ff + IDX_W'(1);

   // merge plan for a free: survivor at p_w, p_d entries drop out after it
   assign r_ok      = r_have_ff && !r_ent_ff.used && r_ent_ff.joinable;
   assign pstart    = !e_ent_ff.joinable || (fi_ff == '0);
   assign take_left = !pstart && !l_ent_ff.used;
   assign p_w       = take_left ? fi_ff - IDX_W'(1) : fi_ff;
   assign p_d       = 2'(take_left) + 2'(r_ok);
   assign p_r0      = CNT_W'(p_w) + CNT_W'(1);
   always_comb begin
      p_ent.start    = take_left ? l_ent_ff.start : e_ent_ff.start;
      p_ent.size     = (take_left ? l_ent_ff.size : '0) + e_ent_ff.size +
                       (r_ok ? r_ent_ff.size : '0);
      p_ent.used     = 1'b0;
      p_ent.joinable = take_left ? l_ent_ff.joinable : e_ent_ff.joinable;
   end

   assign div_tr  = {rem_ff, quo_ff[SIZE_W-1]};
   assign div_ge  = div_tr >= {1'b0, parts_ff};
   assign parts_c = (part_cfg_ff == '0) ? CNT_W'(1) :
                    (32'(part_cfg_ff) > pfa_pkg::MAX_BLOCKS) ? MAX_CNT : CNT_W'(part_cfg_ff);
   assign mv_src  = (func_ff == pfa_pkg::FUNC_ALLOC) ? dst_ff - CNT_W'(1)
                                                     : dst_ff + CNT_W'(mv_d_ff);

   always_comb begin
      fit_mode_in   = fit_mode_ff;
      pool_in       = pool_ff;
      part_cfg_in   = part_cfg_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      func_in       = func_ff;
      req_in        = req_ff;
      addr_in       = addr_ff;
      scan_idx_in   = scan_idx_ff;
      scan_rem_in   = scan_rem_ff;
      pick_valid_in = pick_valid_ff;
      pick_idx_in   = pick_idx_ff;
      pick_ent_in   = pick_ent_ff;
      found_in      = found_ff;
      fi_in         = fi_ff;
      e_ent_in      = e_ent_ff;
      l_ent_in      = l_ent_ff;
      r_ent_in      = r_ent_ff;
      r_have_in     = r_have_ff;
      dst_in        = dst_ff;
      lim_in        = lim_ff;
      mv_d_in       = mv_d_ff;
      quo_in        = quo_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      parts_in      = parts_ff;
      div_cnt_in    = div_cnt_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      wr_en         = 1'b0;
      wr_addr       = pick_idx_ff;
      wr_ent        = rd_ent;
      rd_addr       = scan_idx_ff;

      if (csr_wr_en) begin
         case (csr_index)
            pfa_pkg::CSR_FIT_MODE:   fit_mode_in = csr_wdata[FIT_W-1:0];
            pfa_pkg::CSR_POOL_BYTES: pool_in     = csr_wdata;
            pfa_pkg::CSR_PART_COUNT: part_cfg_in = csr_wdata[PART_W-1:0];
            default: ;
         endcase
      end

      case (ctl.cmd)
         pfa_pkg::CMD_ACCEPT: begin
            func_in       = req_tuser;
            req_in        = req_tdata[SIZE_W-1:0];
            addr_in       = req_tdata[SIZE_W +: ADDR_W];
            scan_idx_in   = (req_tuser == pfa_pkg::FUNC_ALLOC && fit_mode_ff == pfa_pkg::FIT_NEXT
                             && CNT_W'(cursor_ff) < count_ff) ? cursor_ff : '0;
            scan_rem_in   = count_ff;
            pick_valid_in = 1'b0;
            found_in      = 1'b0;
            r_have_in     = 1'b0;
            res_status_in = pfa_pkg::ST_OK;
            res_grant_in  = '0;
         end
         pfa_pkg::CMD_SCAN_RD: rd_addr = scan_idx_ff;
         pfa_pkg::CMD_SCAN_EV: begin
            scan_idx_in = scan_next;
            scan_rem_in = scan_rem_ff - CNT_W'(1);
            if (func_ff == pfa_pkg::FUNC_ALLOC) begin
               if (first_like ? fits : (exact || (bigger && better))) begin
                  pick_valid_in = 1'b1;
                  pick_idx_in   = scan_idx_ff;
                  pick_ent_in   = rd_ent;
               end
            end else if (match) begin
               found_in = 1'b1;
               fi_in    = scan_idx_ff;
               e_ent_in = rd_ent;
            end else begin
               l_ent_in = rd_ent;
            end
         end
         pfa_pkg::CMD_NOFIT:  res_status_in = pfa_pkg::ST_NOFIT;
         pfa_pkg::CMD_FULL:   res_status_in = pfa_pkg::ST_FULL;
         pfa_pkg::CMD_NOADDR: res_status_in = pfa_pkg::ST_BADADDR;
         pfa_pkg::CMD_EXACT: begin
            wr_en         = 1'b1;
            wr_addr       = pick_idx_ff;
            wr_ent        = pick_ent_ff;
            wr_ent.used   = 1'b1;
            res_grant_in  = pick_ent_ff.start;
            if (fit_mode_ff == pfa_pkg::FIT_NEXT) begin
               cursor_in = (CNT_W'(pick_idx_ff) + CNT_W'(1) >= count_ff) ? '0
                                                                         : pick_idx_ff + IDX_W'(1);
            end
         end
         pfa_pkg::CMD_UP_START: begin
            dst_in = count_ff;
            lim_in = CNT_W'(pick_idx_ff) + CNT_W'(1);
         end
         pfa_pkg::CMD_MV_RD: rd_addr = mv_src[IDX_W-1:0];
         pfa_pkg::CMD_MV_WR: begin
            wr_en   = 1'b1;
            wr_addr = dst_ff[IDX_W-1:0];
            wr_ent  = rd_ent;
            dst_in  = (func_ff == pfa_pkg::FUNC_ALLOC) ? dst_ff - CNT_W'(1) : dst_ff + CNT_W'(1);
         end
         pfa_pkg::CMD_SPLIT_HI: begin
            wr_en          = 1'b1;
            wr_addr        = pick_idx_ff + IDX_W'(1);
            wr_ent.start   = pick_ent_ff.start + req_ff[ADDR_W-1:0];
            wr_ent.size    = pick_ent_ff.size - req_ff;
            wr_ent.used    = 1'b0;
            wr_ent.joinable = 1'b1;
         end
         pfa_pkg::CMD_SPLIT_LO: begin
            wr_en        = 1'b1;
            wr_addr      = pick_idx_ff;
            wr_ent       = pick_ent_ff;
            wr_ent.size  = req_ff;
            wr_ent.used  = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            res_grant_in = pick_ent_ff.start;
            if (fit_mode_ff == pfa_pkg::FIT_NEXT) begin
               cursor_in = pick_idx_ff + IDX_W'(1);
            end else if (cursor_ff >= pick_idx_ff) begin
               cursor_in = cursor_ff + IDX_W'(1);
            end
         end
         pfa_pkg::CMD_RD_R: rd_addr = fi_ff + IDX_W'(1);
         pfa_pkg::CMD_R_EV: begin
            r_ent_in  = rd_ent;
            r_have_in = 1'b1;
         end
         pfa_pkg::CMD_PLAN: begin
            wr_en    = 1'b1;
            wr_addr  = p_w;
            wr_ent   = p_ent;
            count_in = count_ff - CNT_W'(p_d);
            dst_in   = p_r0;
            lim_in   = count_ff - CNT_W'(p_d);
            mv_d_in  = p_d;
            if (CNT_W'(cursor_ff) >= p_r0 + CNT_W'(p_d)) begin
               cursor_in = cursor_ff - IDX_W'(p_d);
            end else if (CNT_W'(cursor_ff) >= p_r0) begin
               cursor_in = p_w;
            end
         end
         pfa_pkg::CMD_RB_START: begin
            quo_in     = (pool_ff > POOL_MAX) ? POOL_MAX : pool_ff;
            rem_in     = '0;
            parts_in   = parts_c;
            div_cnt_in = DCNT_W'(SIZE_W);
            count_in   = parts_c;
            cursor_in  = '0;
            dst_in     = '0;
            acc_in     = '0;
         end
         pfa_pkg::CMD_DIV_STEP: begin
            rem_in     = div_ge ? CNT_W'(div_tr - {1'b0, parts_ff}) : CNT_W'(div_tr);
            quo_in     = {quo_ff[SIZE_W-2:0], div_ge};
            div_cnt_in = div_cnt_ff - DCNT_W'(1);
         end
         pfa_pkg::CMD_RB_WRITE: begin
            wr_en          = 1'b1;
            wr_addr        = dst_ff[IDX_W-1:0];
            wr_ent.start   = acc_ff[ADDR_W-1:0];
            wr_ent.size    = stat.rb_last ? quo_ff + SIZE_W'(rem_ff) : quo_ff;
            wr_ent.used    = 1'b0;
            wr_ent.joinable = 1'b0;
            acc_in         = acc_ff + quo_ff;
            dst_in         = dst_ff + CNT_W'(1);
         end
         pfa_pkg::CMD_PUBLISH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = RSP_W'({res_status_ff, res_grant_ff});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= pfa_pkg::FIT_FIRST;
         pool_ff      <= POOL_MAX;
         part_cfg_ff  <= PART_W'(1);
         count_ff     <= CNT_W'(1);
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fit_mode_ff  <= fit_mode_in;
         pool_ff      <= pool_in;
         part_cfg_ff  <= part_cfg_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      req_ff        <= req_in;
      addr_ff       <= addr_in;
      scan_idx_ff   <= scan_idx_in;
      scan_rem_ff   <= scan_rem_in;
      pick_valid_ff <= pick_valid_in;
      pick_idx_ff   <= pick_idx_in;
      pick_ent_ff   <= pick_ent_in;
      found_ff      <= found_in;
      fi_ff         <= fi_in;
      e_ent_ff      <= e_ent_in;
      l_ent_ff      <= l_ent_in;
      r_ent_ff      <= r_ent_in;
      r_have_ff     <= r_have_in;
      dst_ff        <= dst_in;
      lim_ff        <= lim_in;
      mv_d_ff       <= mv_d_in;
      quo_ff        <= quo_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      parts_ff      <= parts_in;
      div_cnt_ff    <= div_cnt_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      stat.req_valid  = req_tvalid;
      stat.func       = func_ff;
      stat.req_zero   = (req_ff == '0);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
      stat.ev_stop    = ev_stop;
      stat.scan_last  = (scan_rem_ff == CNT_W'(1));
      stat.pick_valid = pick_valid_ff;
      stat.pick_exact = (pick_ent_ff.size == req_ff);
      stat.table_full = (count_ff >= MAX_CNT);
      stat.found      = found_ff;
      stat.r_valid    = (CNT_W'(fi_ff) + CNT_W'(1) < count_ff);
      stat.mv_done    = (dst_ff == lim_ff);
      stat.div_done   = (div_cnt_ff == '0);
      stat.rb_last    = (dst_ff + CNT_W'(1) == parts_ff);
   end

   assign req_tready = ctl.take_req;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= MAX_CNT))
      else $error("table count out of range");

   a_cursor_in_table: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(cursor_ff) < count_ff)
      else $error("cursor beyond table");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == pfa_pkg::CMD_PUBLISH) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwrites pending beat");

   a_split_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == pfa_pkg::CMD_SPLIT_LO) |=> (count_ff <= MAX_CNT) && (count_ff > CNT_W'(1)))
      else $error("split with full table");

endmodule

`default_nettype wire

// File: src/pfa_controller.sv
`default_nettype none

module pfa_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  pfa_pkg::dp_stat_type  stat,
   output pfa_pkg::dp_ctl_type   ctl
);

   typedef enum logic [3:0] {
      S_RB_START,
      S_DIV,
      S_RB_WR,
      S_IDLE,
      S_DISPATCH,
      S_SCAN_RD,
      S_SCAN_EV,
      S_ALLOC_RES,
      S_MV_RD,
      S_MV_WR,
      S_SPLIT_HI,
      S_SPLIT_LO,
      S_FREE_RES,
      S_R_EV,
      S_PLAN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      boot_ff, boot_in;

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      ctl.cmd      = pfa_pkg::CMD_NONE;
      ctl.take_req = 1'b0;
      case (state_ff)
         S_RB_START: begin
            ctl.cmd  = pfa_pkg::CMD_RB_START;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_RB_WR;
            end else begin
               ctl.cmd = pfa_pkg::CMD_DIV_STEP;
            end
         end
         S_RB_WR: begin
            ctl.cmd = pfa_pkg::CMD_RB_WRITE;
            if (stat.rb_last) begin
               state_in = boot_ff ? S_IDLE : S_DONE;
               boot_in  = 1'b0;
            end
         end
         S_IDLE: begin
            ctl.take_req = 1'b1;
            if (stat.req_valid) begin
               ctl.cmd  = pfa_pkg::CMD_ACCEPT;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.func)
               pfa_pkg::FUNC_ALLOC: begin
                  if (stat.req_zero) begin
                     ctl.cmd  = pfa_pkg::CMD_NOFIT;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               pfa_pkg::FUNC_FREE:    state_in = S_SCAN_RD;
               pfa_pkg::FUNC_REBUILD: state_in = S_RB_START;
               default:               state_in = S_DONE;
            endcase
         end
         S_SCAN_RD: begin
            ctl.cmd  = pfa_pkg::CMD_SCAN_RD;
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            ctl.cmd = pfa_pkg::CMD_SCAN_EV;
            if (stat.ev_stop || stat.scan_last) begin
               state_in = (stat.func == pfa_pkg::FUNC_ALLOC) ? S_ALLOC_RES : S_FREE_RES;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_ALLOC_RES: begin
            if (!stat.pick_valid) begin
               ctl.cmd  = pfa_pkg::CMD_NOFIT;
               state_in = S_DONE;
            end else if (stat.pick_exact) begin
               ctl.cmd  = pfa_pkg::CMD_EXACT;
               state_in = S_DONE;
            end else if (stat.table_full) begin
               ctl.cmd  = pfa_pkg::CMD_FULL;
               state_in = S_DONE;
            end else begin
               ctl.cmd  = pfa_pkg::CMD_UP_START;
               state_in = S_MV_RD;
            end
         end
         S_MV_RD: begin
            if (stat.mv_done) begin
               state_in = (stat.func == pfa_pkg::FUNC_ALLOC) ? S_SPLIT_HI : S_DONE;
            end else begin
               ctl.cmd  = pfa_pkg::CMD_MV_RD;
               state_in = S_MV_WR;
            end
         end
         S_MV_WR: begin
            ctl.cmd  = pfa_pkg::CMD_MV_WR;
            state_in = S_MV_RD;
         end
         S_SPLIT_HI: begin
            ctl.cmd  = pfa_pkg::CMD_SPLIT_HI;
            state_in = S_SPLIT_LO;
         end
         S_SPLIT_LO: begin
            ctl.cmd  = pfa_pkg::CMD_SPLIT_LO;
            state_in = S_DONE;
         end
         S_FREE_RES: begin
            if (!stat.found) begin
               ctl.cmd  = pfa_pkg::CMD_NOADDR;
               state_in = S_DONE;
            end else if (stat.r_valid) begin
               ctl.cmd  = pfa_pkg::CMD_RD_R;
               state_in = S_R_EV;
            end else begin
               state_in = S_PLAN;
            end
         end
         S_R_EV: begin
            ctl.cmd  = pfa_pkg::CMD_R_EV;
            state_in = S_PLAN;
         end
         S_PLAN: begin
            ctl.cmd  = pfa_pkg::CMD_PLAN;
            state_in = S_MV_RD;
         end
         S_DONE: begin
            if (stat.out_free) begin
               ctl.cmd  = pfa_pkg::CMD_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RB_START;
         boot_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
      end
   end

   a_boot_quiet: assert property (@(posedge clock) disable iff (reset)
      boot_ff |-> (ctl.cmd != pfa_pkg::CMD_PUBLISH) && !ctl.take_req)
      else $error("beat moved during power-up rebuild");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == pfa_pkg::CMD_ACCEPT) |-> (state_ff == S_IDLE) && stat.req_valid)
      else $error("accept outside idle");

   a_split_pair: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == pfa_pkg::CMD_SPLIT_HI) |=> (ctl.cmd == pfa_pkg::CMD_SPLIT_LO))
      else $error("split halves separated");

endmodule

`default_nettype wire

// File: src/partition_fit_allocator.sv
`default_nettype none

// Partition fit allocator. Keeps an address-ordered table of up to 64 blocks
// (start, size, used, partition-start mark) in one RAM and serves one command
// beat at a time: allocate (first, next, best or worst fit), free (with merge
// of free neighbors inside the same partition) and rebuild from the csr
// registers. Each request beat yields exactly one response beat carrying the
// granted address and a status code. Flow: a command scans the table one entry
// at a time (RAM read, then evaluate) and stops at the first hit where the
// fit mode allows. A split then moves every entry behind the picked one up by
// one slot, and a free rewrites every entry behind the freed one, one entry at
// a time through the table RAM (read, then write), before leaving the move
// loop. Around scan and move a command also passes through accept, dispatch,
// result decision, neighbor read or split writes, and response. A rebuild runs
// a bit-serial divider (setup, 21 steps, exit) and then writes one partition
// per cycle. The slowest command is a best or worst fit split on a table of
// 63 entries. After reset the block rebuilds itself before raising req_tready.
// The response sits in its own output register, so the next request is taken
// while that beat waits on rsp_tready.
module partition_fit_allocator (
   input  logic                             clock,
   input  logic                             reset,
   // request: tuser = func; tdata = request_bytes[20:0], block_address[40:21]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pfa_pkg::FUNC_W-1:0]       req_tuser,
   input  logic [pfa_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response: tdata = granted_address[19:0], status[21:20]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pfa_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // csr: 0 fit_mode, 1 pool_bytes, 2 partition_count
   input  logic                             csr_wr_en,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfa_pkg::SIZE_W-1:0]       csr_wdata
);

   pfa_pkg::dp_ctl_type  ctl;
   pfa_pkg::dp_stat_type stat;

   // sequencer: walks scan, shift and rebuild steps
   pfa_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // table RAM, csr registers, divider and result beat
   pfa_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ctl        (ctl),
      .stat       (stat)
   );

endmodule

`default_nettype wire

// File: sim/pfa_checker.sv
`default_nettype none

module pfa_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pfa_pkg::FUNC_W-1:0]      req_tuser,
   input  logic [pfa_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pfa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfa_pkg::SIZE_W-1:0]      csr_wdata,
   output int                              errors,
   output int                              pending,
   output int                              n_ok,
   output int                              n_nofit,
   output int                              n_badaddr,
   output int                              n_full
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [pfa_pkg::ADDR_W-1:0] addr;
      pfa_pkg::status_type        st;
   } grant_type;

   // shadow of the block table
   longint blk_start [pfa_pkg::MAX_BLOCKS];
   longint blk_size  [pfa_pkg::MAX_BLOCKS];
   bit     blk_used  [pfa_pkg::MAX_BLOCKS];
   bit     blk_join  [pfa_pkg::MAX_BLOCKS];
   int     blk_count;
   int     cursor;

   pfa_pkg::fit_type           fit_reg;
   logic [pfa_pkg::SIZE_W-1:0] pool_reg;
   logic [pfa_pkg::PART_W-1:0] part_reg;

   grant_type grant_q[$];

   function automatic void rebuild_blocks();
      longint pool, parts, stride;
      pool  = pool_reg;
      parts = part_reg;
      if (pool > (64'd1 << pfa_pkg::ADDR_BITS)) pool = 64'd1 << pfa_pkg::ADDR_BITS;
      if (parts == 0) parts = 1;
      if (parts > pfa_pkg::MAX_BLOCKS) parts = pfa_pkg::MAX_BLOCKS;
      stride = pool / parts;
      for (int i = 0; i < parts; i++) begin
         blk_start[i] = i * stride;
         blk_size[i]  = (i == parts - 1) ? stride + pool % parts : stride;
         blk_used[i]  = 0;
         blk_join[i]  = 0;
      end
      blk_count = int'(parts);
      cursor    = 0;
   endfunction

   function automatic void erase_blk(int r, bit keep_left);
      for (int k = r; k + 1 < blk_count; k++) begin
         blk_start[k] = blk_start[k+1];
         blk_size[k]  = blk_size[k+1];
         blk_used[k]  = blk_used[k+1];
         blk_join[k]  = blk_join[k+1];
      end
      blk_count--;
      if (cursor > r) cursor--;
      else if (cursor == r && keep_left && r > 0) cursor = r - 1;
   endfunction

   function automatic bit split_blk(int i, longint n);
      if (blk_count >= pfa_pkg::MAX_BLOCKS) return 0;
      for (int k = blk_count; k > i + 1; k--) begin
         blk_start[k] = blk_start[k-1];
         blk_size[k]  = blk_size[k-1];
         blk_used[k]  = blk_used[k-1];
         blk_join[k]  = blk_join[k-1];
      end
      blk_start[i+1] = blk_start[i] + n;
      blk_size[i+1]  = blk_size[i] - n;
      blk_used[i+1]  = 0;
      blk_join[i+1]  = 1;
      blk_size[i]    = n;
      blk_used[i]    = 1;
      blk_count++;
      if (cursor >= i) cursor++;
      return 1;
   endfunction

   function automatic pfa_pkg::status_type grant_blk(longint n, output longint a);
      int pick, c, i, saved;
      a    = 0;
      pick = blk_count;
      if (n == 0) return pfa_pkg::ST_NOFIT;
      if (fit_reg == pfa_pkg::FIT_FIRST) begin
         for (i = 0; i < blk_count; i++)
            if (!blk_used[i] && blk_size[i] >= n) begin
               pick = i;
               break;
            end
      end else if (fit_reg == pfa_pkg::FIT_NEXT) begin
         c = (cursor < blk_count) ? cursor : 0;
         for (int k = 0; k < blk_count; k++) begin
            i = (c + k) % blk_count;
            if (!blk_used[i] && blk_size[i] >= n) begin
               pick = i;
               break;
            end
         end
      end else begin
         // exact size wins first, then smallest/largest larger block
         for (i = 0; i < blk_count; i++)
            if (!blk_used[i] && blk_size[i] == n) begin
               pick = i;
               break;
            end
         if (pick == blk_count)
            for (i = 0; i < blk_count; i++) begin
               if (blk_used[i] || blk_size[i] <= n) continue;
               if (pick == blk_count ||
                   (fit_reg == pfa_pkg::FIT_BEST && blk_size[i] < blk_size[pick]) ||
                   (fit_reg == pfa_pkg::FIT_WORST && blk_size[i] > blk_size[pick]))
                  pick = i;
            end
      end
      if (pick >= blk_count) return pfa_pkg::ST_NOFIT;
      if (blk_size[pick] == n) begin
         blk_used[pick] = 1;
         if (fit_reg == pfa_pkg::FIT_NEXT)
            cursor = (pick + 1 >= blk_count) ? 0 : pick + 1;
      end else begin
         saved = cursor;
         if (fit_reg == pfa_pkg::FIT_NEXT) cursor = pick;
         if (!split_blk(pick, n)) begin
            cursor = saved;
            return pfa_pkg::ST_FULL;
         end
      end
      a = blk_start[pick];
      return pfa_pkg::ST_OK;
   endfunction

   function automatic pfa_pkg::status_type release_blk(longint a);
      int  i;
      bit  right_ok;
      for (i = 0; i < blk_count; i++)
         if (blk_used[i] && blk_start[i] == a) break;
      if (i >= blk_count) return pfa_pkg::ST_BADADDR;
      blk_used[i] = 0;
      right_ok = (i + 1 < blk_count) && !blk_used[i+1] && blk_join[i+1];
      if (!blk_join[i] || i == 0) begin
         // partition start: only absorbs its right neighbor
         if (right_ok) begin
            blk_size[i] += blk_size[i+1];
            erase_blk(i + 1, 1);
         end
      end else if (!blk_used[i-1] && right_ok) begin
         blk_size[i-1] += blk_size[i] + blk_size[i+1];
         erase_blk(i + 1, 1);
         erase_blk(i, 1);
      end else if (!blk_used[i-1]) begin
         blk_size[i-1] += blk_size[i];
         erase_blk(i, 1);
      end else if (right_ok) begin
         blk_start[i+1] = blk_start[i];
         blk_size[i+1] += blk_size[i];
         erase_blk(i, 0);
      end
      return pfa_pkg::ST_OK;
   endfunction

   assign pending = grant_q.size();

   always @(posedge clock) begin
      grant_type g, exp_g;
      longint    a;
      if (reset) begin
         fit_reg  = pfa_pkg::FIT_FIRST;
         pool_reg = 21'd1048576;
         part_reg = 7'd1;
         rebuild_blocks();
         grant_q.delete();
         errors = 0; n_ok = 0; n_nofit = 0; n_badaddr = 0; n_full = 0;
      end else begin
         if (csr_wr_en)
            case (csr_index)
               pfa_pkg::CSR_FIT_MODE:
                  fit_reg = pfa_pkg::fit_type'(csr_wdata[pfa_pkg::FIT_W-1:0]);
               pfa_pkg::CSR_POOL_BYTES: pool_reg = csr_wdata;
               pfa_pkg::CSR_PART_COUNT: part_reg = csr_wdata[pfa_pkg::PART_W-1:0];
               default: ;
            endcase
         // response first: it can never belong to a beat taken at this edge
         if (rsp_tvalid && rsp_tready) begin
            if (grant_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t unexpected response beat %h", $realtime, rsp_tdata);
            end else begin
               exp_g = grant_q.pop_front();
               case (exp_g.st)
                  pfa_pkg::ST_OK:      n_ok++;
                  pfa_pkg::ST_NOFIT:   n_nofit++;
                  pfa_pkg::ST_BADADDR: n_badaddr++;
                  default:             n_full++;
               endcase
               if (rsp_tdata[pfa_pkg::ADDR_W-1:0] !== exp_g.addr ||
                   rsp_tdata[pfa_pkg::ADDR_W +: pfa_pkg::STATUS_W] !== exp_g.st) begin
                  errors++;
                  if (errors <= 10)
                     $display("%t mismatch: expected addr %h status %0d, got addr %h status %0d",
                              $realtime, exp_g.addr, exp_g.st,
                              rsp_tdata[pfa_pkg::ADDR_W-1:0],
                              rsp_tdata[pfa_pkg::ADDR_W +: pfa_pkg::STATUS_W]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            a    = 0;
            g.st = pfa_pkg::ST_OK;
            case (req_tuser)
               pfa_pkg::FUNC_ALLOC:
                  g.st = grant_blk(longint'(req_tdata[pfa_pkg::SIZE_W-1:0]), a);
               pfa_pkg::FUNC_FREE:
                  g.st = release_blk(
                     longint'(req_tdata[pfa_pkg::SIZE_W +: pfa_pkg::ADDR_W]));
               pfa_pkg::FUNC_REBUILD: rebuild_blocks();
               default: ;
            endcase
            g.addr = a[pfa_pkg::ADDR_W-1:0];
            grant_q.insert(grant_q.size(), g);
         end
      end
   end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // command code the block must treat as a no-op
   localparam logic [pfa_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;
   // cycles with no beat on any channel before giving up
   localparam int STALL_LIMIT = 20000;
   localparam int PHASES      = 8;

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            req_tvalid = 0;
   logic                            req_tready;
   logic [pfa_pkg::FUNC_W-1:0]      req_tuser = '0;
   logic [pfa_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 0;
   logic [pfa_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_wr_en = 0;
   pfa_pkg::csr_type                csr_index = pfa_pkg::CSR_FIT_MODE;
   logic [pfa_pkg::SIZE_W-1:0]      csr_wdata = '0;

   int errors, pending, n_ok, n_nofit, n_badaddr, n_full;

   // idle and stall odds in percent
   int send_idle = 0;
   int rsp_stall = 0;

   // allocations the block granted, used to build well-formed frees
   typedef struct {
      logic [pfa_pkg::FUNC_W-1:0] func;
      int                         gen;
   } sent_type;
   sent_type                   sent_q[$];
   logic [pfa_pkg::ADDR_W-1:0] live_q[$];
   int                         gen = 0;
   int                         n_beats = 0;
   int                         quiet = 0;

   always #5 clock = ~clock;

   partition_fit_allocator i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   pfa_checker i_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_wr_en, .csr_index, .csr_wdata,
      .errors, .pending, .n_ok, .n_nofit, .n_badaddr, .n_full
   );

   // receiver side stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall);

   // harvest granted addresses; drop ones from before the last rebuild
   always @(posedge clock) begin
      sent_type s;
      if (!reset && rsp_tvalid && rsp_tready && sent_q.size() > 0) begin
         s = sent_q.pop_front();
         if (s.func == pfa_pkg::FUNC_ALLOC && s.gen == gen &&
             rsp_tdata[pfa_pkg::ADDR_W +: pfa_pkg::STATUS_W] == pfa_pkg::ST_OK)
            live_q.insert(live_q.size(), rsp_tdata[pfa_pkg::ADDR_W-1:0]);
      end
   end

   // watchdog: any beat on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("FAIL partition_fit_allocator");
         $finish;
      end
   end

   task automatic send_beat(logic [pfa_pkg::FUNC_W-1:0] f,
                            logic [pfa_pkg::SIZE_W-1:0] nbytes,
                            logic [pfa_pkg::ADDR_W-1:0] a);
      sent_type s;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= f;
      req_tdata  <= {{(pfa_pkg::REQ_TDATA_W-pfa_pkg::SIZE_W-pfa_pkg::ADDR_W){1'b0}},
                     a, nbytes};
      do @(posedge clock); while (!req_tready);
      if (f == pfa_pkg::FUNC_REBUILD) begin
         gen++;
         live_q.delete();
      end
      s.func = f;
      s.gen  = gen;
      sent_q.insert(sent_q.size(), s);
      n_beats++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sent_q.size() > 0) @(posedge clock);
      // quiet gap before the registers change
      repeat (300) @(posedge clock);
   endtask

   // caller drops the write enable after the last write
   task automatic write_csr(pfa_pkg::csr_type idx, logic [pfa_pkg::SIZE_W-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // idle between calls, then load registers and rebuild
   task automatic reconfigure(pfa_pkg::fit_type fm, logic [pfa_pkg::SIZE_W-1:0] pool,
                              logic [pfa_pkg::SIZE_W-1:0] parts);
      drain();
      write_csr(pfa_pkg::CSR_FIT_MODE, pfa_pkg::SIZE_W'(fm));
      write_csr(pfa_pkg::CSR_POOL_BYTES, pool);
      write_csr(pfa_pkg::CSR_PART_COUNT, parts);
      csr_wr_en <= 0;
      send_beat(pfa_pkg::FUNC_REBUILD, '0, '0);
   endtask

   task automatic free_one();
      int k;
      if (live_q.size() > 0 && $urandom_range(9) != 0) begin
         k = $urandom_range(live_q.size() - 1);
         send_beat(pfa_pkg::FUNC_FREE, pfa_pkg::SIZE_W'($urandom), live_q[k]);
         live_q.delete(k);
      end else
         send_beat(pfa_pkg::FUNC_FREE, pfa_pkg::SIZE_W'($urandom),
                   pfa_pkg::ADDR_W'($urandom));
   endtask

   initial begin
      logic [pfa_pkg::SIZE_W-1:0] pool_v, part_v, eff, sz;
      logic [pfa_pkg::SIZE_W-1:0] sizes[3];
      int                         r, quota;

      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: reset config, single partition spanning the whole pool
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd0, '0);              // zero request
      send_beat(pfa_pkg::FUNC_ALLOC, 21'h1FFFFF, '0);         // beyond pool
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd1048576, 20'hFFFFF); // exact whole pool
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd1, '0);              // nothing left
      send_beat(pfa_pkg::FUNC_FREE, '0, '0);
      send_beat(pfa_pkg::FUNC_FREE, '0, 20'hFFFFF);           // unknown address
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd100, '0);            // split
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd200, '0);
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd300, '0);
      send_beat(pfa_pkg::FUNC_FREE, '0, 20'd100);             // both neighbors used
      send_beat(pfa_pkg::FUNC_FREE, '0, 20'd300);             // triple merge
      send_beat(pfa_pkg::FUNC_FREE, '0, 20'd0);               // partition start merges right
      send_beat(FUNC_NOP, 21'h1FFFFF, 20'hFFFFF);
      // 64 partitions: any split hits a full table
      reconfigure(pfa_pkg::FIT_FIRST, 21'd1048576, 21'd64);
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd5, '0);
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd16384, '0);
      // stride zero: only the last partition holds bytes
      reconfigure(pfa_pkg::FIT_NEXT, 21'd1, 21'd127);
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd1, '0);
      send_beat(pfa_pkg::FUNC_ALLOC, 21'd1, '0);
      send_beat(pfa_pkg::FUNC_FREE, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         case (p % 6)
            0: begin pool_v = 21'd1048576; part_v = 21'd1;  end
            1: begin pool_v = 21'h1FFFFF;  part_v = 21'd0;  end
            2: begin pool_v = 21'd4096;    part_v = 21'd7;  end
            3: begin pool_v = 21'd1000;    part_v = 21'd64; end
            4: begin pool_v = 21'd64;      part_v = 21'd3;  end
            default: begin
               pool_v = pfa_pkg::SIZE_W'($urandom_range(1, 1 << 20));
               part_v = pfa_pkg::SIZE_W'($urandom_range(1, 64));
            end
         endcase
         reconfigure(pfa_pkg::fit_type'(p % 4), pool_v, part_v);
         case (p % 4)
            0: begin send_idle = 0;  rsp_stall = 0;  end
            1: begin send_idle = 82; rsp_stall = 0;  end
            2: begin send_idle = 0;  rsp_stall = 82; end
            default: begin send_idle = 33; rsp_stall = 33; end
         endcase
         eff = (pool_v > 21'd1048576) ? 21'd1048576 : pool_v;
         // a few recurring sizes make exact fits common
         for (int k = 0; k < 3; k++)
            sizes[k] = pfa_pkg::SIZE_W'($urandom_range(1, eff / 32 + 1));
         quota = (p % 4 == 1) ? 60 : 110;
         for (int n = 0; n < quota; n++) begin
            if (p == 3 && n == quota / 2) drain();   // let the pipe run dry once
            r = $urandom_range(99);
            if (r < 50) begin
               case ($urandom_range(9))
                  0:       sz = pfa_pkg::SIZE_W'($urandom);
                  1:       sz = '0;
                  2, 3, 4: sz = sizes[$urandom_range(2)];
                  default: sz = pfa_pkg::SIZE_W'($urandom_range(1, eff / 8 + 1));
               endcase
               send_beat(pfa_pkg::FUNC_ALLOC, sz, pfa_pkg::ADDR_W'($urandom));
            end else if (r < 95)
               free_one();
            else if (r < 98)
               send_beat(pfa_pkg::FUNC_REBUILD, pfa_pkg::SIZE_W'($urandom),
                         pfa_pkg::ADDR_W'($urandom));
            else
               send_beat(FUNC_NOP, pfa_pkg::SIZE_W'($urandom), pfa_pkg::ADDR_W'($urandom));
         end
      end

      req_tvalid <= 0;
      rsp_stall  = 0;
      while (pending > 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Ran %0d commands over %0d register settings and all four fit policies.",
               n_beats, PHASES + 2);
      $display("Outcomes: %0d ok, %0d no fit, %0d bad free, %0d table full.",
               n_ok, n_nofit, n_badaddr, n_full);
      if (errors == 0 && pending == 0)
         $display("PASS partition_fit_allocator");
      else
         $display("FAIL partition_fit_allocator");
      $finish;
   end

endmodule

`default_nettype wire

// File: partition_fit_allocator.f
src/pfa_pkg.sv
src/pfa_ram.sv
src/pfa_datapath.sv
src/pfa_controller.sv
src/partition_fit_allocator.sv
sim/pfa_checker.sv
sim/testbench.sv
